// ===== design/clj_pkg.sv =====
// Shared types, constants and register codes for the cut-off contact force block.
package clj_pkg;

   localparam int LEN_W   = 31;
   localparam int GAP_W   = 32;
   localparam int DIST_W  = 34;
   localparam int DEN_W   = 33;
   localparam int NRM_W   = 16;
   localparam int FRC_W   = 48;
   localparam int WIDE_W  = 64;
   localparam int PROD_W  = 64;
   localparam int DIFF_W  = 51;
   localparam int QSH_W   = 50;
   localparam int AXES    = 3;
   localparam int DIV_STEPS = 64;
   localparam int CSR_IDX_W = 2;
   localparam int LJ_SCALE  = 24;

   localparam logic [CSR_IDX_W-1:0] REG_WELL_DEPTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONTACT_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF_DISTANCE = 2'd2;

   localparam logic [LEN_W-1:0] WELL_DEPTH_RESET      = 31'd65536;
   localparam logic [LEN_W-1:0] CONTACT_LENGTH_RESET  = 31'd65536;
   localparam logic [LEN_W-1:0] CUTOFF_DISTANCE_RESET = 31'd73561;

   localparam logic [WIDE_W-1:0] WIDE_MAX  = {WIDE_W{1'b1}};
   localparam logic [WIDE_W-1:0] SCALE_LIM = WIDE_MAX / LJ_SCALE;
   localparam logic [FRC_W-1:0]  FRC_MAX   = {1'b0, {(FRC_W-1){1'b1}}};
   localparam logic [FRC_W-1:0]  FRC_MIN   = {1'b1, {(FRC_W-1){1'b0}}};

   typedef struct packed {
      logic [AXES-1:0][FRC_W-1:0] fin;
      logic [AXES-1:0][NRM_W-1:0] nrm;
      logic [DEN_W-1:0]           den;
      logic                       near;
      logic                       nonpos;
      logic                       neg;
      logic                       sat;
   } side_type;

endpackage

// ===== design/clj_ifaces.sv =====
// Handshake channel interfaces for contacts, results and register writes.
interface clj_req_if;
   logic               valid;
   logic               ready;
   logic [30:0]        radius_a;
   logic [30:0]        radius_b;
   logic signed [31:0] surface_gap;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic signed [47:0] force_in_x;
   logic signed [47:0] force_in_y;
   logic signed [47:0] force_in_z;
   modport source (output valid, radius_a, radius_b, surface_gap, normal_x, normal_y,
                   normal_z, force_in_x, force_in_y, force_in_z, input ready);
   modport sink (input valid, radius_a, radius_b, surface_gap, normal_x, normal_y,
                 normal_z, force_in_x, force_in_y, force_in_z, output ready);
endinterface

interface clj_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] force_out_x;
   logic signed [47:0] force_out_y;
   logic signed [47:0] force_out_z;
   logic               within_cutoff;
   logic               saturated;
   modport source (output valid, force_out_x, force_out_y, force_out_z, within_cutoff,
                   saturated, input ready);
   modport sink (input valid, force_out_x, force_out_y, force_out_z, within_cutoff,
                 saturated, output ready);
endinterface

interface clj_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [30:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/clj_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module clj_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [clj_pkg::WIDE_W-1:0]  in_num,
   input  clj_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [clj_pkg::WIDE_W-1:0]  out_quo,
   output clj_pkg::side_type           out_side
);
   import clj_pkg::*;

   logic              v_ff    [DIV_STEPS];
   logic [DEN_W-1:0]  rem_ff  [DIV_STEPS];
   logic [WIDE_W-1:0] nq_ff   [DIV_STEPS];
   side_type          side_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [WIDE_W-1:0] nq_prev;
      side_type          side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [WIDE_W-1:0] nq_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign nq_prev   = in_num;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign nq_prev   = nq_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, nq_prev[WIDE_W-1]};
         ge     = trial >= {1'b0, side_prev.den};
         rem_in = ge ? DEN_W'(trial - {1'b0, side_prev.den}) : trial[DEN_W-1:0];
         nq_in  = {nq_prev[WIDE_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[DIV_STEPS-1];
   assign out_quo   = nq_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

// ===== design/clj_mulq.sv =====
// Two-stage saturating Q32.32 multiplier built from four 32 by 32 partial products.
module clj_mulq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [clj_pkg::WIDE_W-1:0]  in_a,
   input  logic [clj_pkg::WIDE_W-1:0]  in_b,
   input  logic [clj_pkg::WIDE_W-1:0]  in_keep,
   input  clj_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [clj_pkg::WIDE_W-1:0]  out_prod,
   output logic [clj_pkg::WIDE_W-1:0]  out_keep,
   output clj_pkg::side_type           out_side
);
   import clj_pkg::*;

   localparam int HALF_W = WIDE_W / 2;
   localparam int SUM_W  = WIDE_W + HALF_W + 2;

   logic              v1_ff;
   logic [WIDE_W-1:0] hh_ff, hl_ff, lh_ff, ll_ff, keep1_ff;
   side_type          side1_ff;
   logic              v2_ff;
   logic [WIDE_W-1:0] prod_ff, keep2_ff;
   side_type          side2_ff;
   logic [SUM_W-1:0]  sum;
   logic              clip;
   logic [WIDE_W-1:0] prod_in;
   side_type          side2_in;

   always_comb begin
      sum = SUM_W'({hh_ff, {HALF_W{1'b0}}})
          + SUM_W'(hl_ff) + SUM_W'(lh_ff) + SUM_W'(ll_ff[WIDE_W-1:HALF_W]);
      clip = |sum[SUM_W-1:WIDE_W];
      prod_in = clip ? WIDE_MAX : sum[WIDE_W-1:0];
      side2_in = side1_ff;
      side2_in.sat = side1_ff.sat | clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff    <= in_a[WIDE_W-1:HALF_W] * in_b[WIDE_W-1:HALF_W];
         hl_ff    <= in_a[WIDE_W-1:HALF_W] * in_b[HALF_W-1:0];
         lh_ff    <= in_a[HALF_W-1:0] * in_b[WIDE_W-1:HALF_W];
         ll_ff    <= in_a[HALF_W-1:0] * in_b[HALF_W-1:0];
         keep1_ff <= in_keep;
         side1_ff <= in_side;
         prod_ff  <= prod_in;
         keep2_ff <= keep1_ff;
         side2_ff <= side2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_keep  = keep2_ff;
   assign out_side  = side2_ff;

endmodule

// ===== design/clj_apply.sv =====
// Signed force selection, projection onto the normal and saturating accumulation.
module clj_apply (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [clj_pkg::WIDE_W-1:0]        in_mag,
   input  clj_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic [clj_pkg::AXES-1:0][clj_pkg::FRC_W-1:0] out_force,
   output logic                              out_within,
   output logic                              out_sat
);
   import clj_pkg::*;

   logic                              va_ff, vb_ff, vc_ff;
   logic signed [FRC_W-1:0]           f_ff;
   side_type                          sa_ff, sb_ff;
   logic signed [PROD_W-1:0]          p_ff [AXES];
   logic [AXES-1:0][FRC_W-1:0]        frc_ff;
   logic                              near_ff, sat_ff;

   logic [FRC_W-1:0]                  fmc;
   logic                              fclip;
   logic signed [FRC_W-1:0]           f_in;
   side_type                          sa_in;
   logic signed [PROD_W-1:0]          p_in [AXES];
   logic signed [QSH_W-1:0]           q [AXES];
   logic signed [DIFF_W-1:0]          diff [AXES];
   logic [AXES-1:0][FRC_W-1:0]        frc_in;
   logic [AXES-1:0]                   clip;

   always_comb begin
      fclip = in_mag > WIDE_W'(FRC_MAX);
      fmc   = fclip ? FRC_MAX : in_mag[FRC_W-1:0];
      sa_in = in_side;
      if (!in_side.near) begin
         f_in = '0;
         sa_in.sat = 1'b0;
      end else if (in_side.nonpos) begin
         f_in = FRC_MAX;
         sa_in.sat = 1'b1;
      end else begin
         f_in = in_side.neg ? -$signed(fmc) : $signed(fmc);
         sa_in.sat = in_side.sat | fclip;
      end
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         p_in[k] = f_ff * $signed(sa_ff.nrm[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         q[k]    = p_ff[k][PROD_W-1:PROD_W-QSH_W];
         diff[k] = DIFF_W'($signed(sb_ff.fin[k])) - DIFF_W'(q[k]);
         clip[k] = 1'b0;
         if (diff[k] > $signed(DIFF_W'($signed(FRC_MAX)))) begin
            frc_in[k] = FRC_MAX;
            clip[k]   = 1'b1;
         end else if (diff[k] < $signed(DIFF_W'($signed(FRC_MIN)))) begin
            frc_in[k] = FRC_MIN;
            clip[k]   = 1'b1;
         end else begin
            frc_in[k] = diff[k][FRC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff      <= f_in;
         sa_ff     <= sa_in;
         p_ff      <= p_in;
         sb_ff     <= sa_ff;
         frc_ff    <= frc_in;
         near_ff   <= sb_ff.near;
         sat_ff    <= sb_ff.sat | (|clip);
      end
   end

   assign out_valid  = vc_ff;
   assign out_force  = frc_ff;
   assign out_within = near_ff;
   assign out_sat    = sat_ff;

endmodule

// ===== design/cutoff_lj_contact_force.sv =====
// Top level of the cut-off Lennard-Jones contact force pipeline.
//
//   channel   direction  payload
//   req_ch    in         radii, surface gap, contact normal, running force
//   rsp_ch    out        updated force, within-cutoff flag, saturation flag
//   csr_ch    in         register index and 31-bit data, always ready
//
// One word is taken every cycle while the pipeline is not held. The pipeline is made
// of the two 64-stage dividers, five two-stage multipliers and six single stages.
// Reset clears the valid bits and loads the register defaults. When the result word
// is not taken, the whole pipeline holds.
module cutoff_lj_contact_force (
   input  logic      clock,
   input  logic      reset,
   clj_req_if.sink   req_ch,
   clj_rsp_if.source rsp_ch,
   clj_csr_if.sink   csr_ch
);
   import clj_pkg::*;

   logic [LEN_W-1:0] well_depth_ff, contact_length_ff, cutoff_distance_ff;
   logic             en;

   logic                     v0_ff;
   side_type                 s0_ff;
   logic signed [DIST_W-1:0] ctr_dist;
   side_type                 s0_in;

   logic              d1_v;
   logic [WIDE_W-1:0] rho;
   side_type          d1_s;
   logic              m1_v, m2_v, m3_v, m4_v, m5_v, d2_v, ap_v;
   logic [WIDE_W-1:0] r2, r2k, r4, r4k, r6, r6k, r12, r12k, g, gk, fm;
   side_type          m1_s, m2_s, m3_s, m4_s, m5_s, d2_s;

   logic              vc_ff, vg_ff;
   logic [WIDE_W-1:0] mag_ff, g24_ff;
   side_type          sc_ff, sg_ff;
   logic [WIDE_W-1:0] two12, mag_in, g24_in;
   logic              neg_in, t_clip, g_clip;
   side_type          sc_in, sg_in;

   logic [AXES-1:0][FRC_W-1:0] frc;
   logic                       in_cut, sat;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         well_depth_ff      <= WELL_DEPTH_RESET;
         contact_length_ff  <= CONTACT_LENGTH_RESET;
         cutoff_distance_ff <= CUTOFF_DISTANCE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_WELL_DEPTH: begin
               well_depth_ff <= csr_ch.data;
            end
            REG_CONTACT_LENGTH: begin
               contact_length_ff <= csr_ch.data;
            end
            REG_CUTOFF_DISTANCE: begin
               cutoff_distance_ff <= csr_ch.data;
            end
            default: begin
            end
         endcase
      end
   end

   assign en           = !ap_v || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      ctr_dist = DIST_W'(req_ch.surface_gap) + $signed({3'b000, req_ch.radius_a})
               + $signed({3'b000, req_ch.radius_b});
      s0_in.fin    = {req_ch.force_in_z, req_ch.force_in_y, req_ch.force_in_x};
      s0_in.nrm    = {req_ch.normal_z, req_ch.normal_y, req_ch.normal_x};
      s0_in.den    = ctr_dist[DEN_W-1:0];
      s0_in.near   = ctr_dist < $signed({3'b000, cutoff_distance_ff});
      s0_in.nonpos = ctr_dist[DIST_W-1] || (ctr_dist == '0);
      s0_in.neg    = 1'b0;
      s0_in.sat    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         vc_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_ch.valid;
         vc_ff <= m4_v;
         vg_ff <= m5_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff  <= s0_in;
         mag_ff <= mag_in;
         sc_ff  <= sc_in;
         g24_ff <= g24_in;
         sg_ff  <= sg_in;
      end
   end

   clj_div u_div_rho (
      .clock, .reset, .en,
      .in_valid (v0_ff),
      .in_num   ({1'b0, contact_length_ff, 32'd0}),
      .in_side  (s0_ff),
      .out_valid(d1_v),
      .out_quo  (rho),
      .out_side (d1_s)
   );

   clj_mulq u_mul_r2 (
      .clock, .reset, .en,
      .in_valid(d1_v), .in_a(rho), .in_b(rho), .in_keep('0), .in_side(d1_s),
      .out_valid(m1_v), .out_prod(r2), .out_keep(r2k), .out_side(m1_s)
   );

   clj_mulq u_mul_r4 (
      .clock, .reset, .en,
      .in_valid(m1_v), .in_a(r2), .in_b(r2), .in_keep(r2), .in_side(m1_s),
      .out_valid(m2_v), .out_prod(r4), .out_keep(r4k), .out_side(m2_s)
   );

   clj_mulq u_mul_r6 (
      .clock, .reset, .en,
      .in_valid(m2_v), .in_a(r4), .in_b(r4k), .in_keep(r2k), .in_side(m2_s),
      .out_valid(m3_v), .out_prod(r6), .out_keep(r6k), .out_side(m3_s)
   );

   clj_mulq u_mul_r12 (
      .clock, .reset, .en,
      .in_valid(m3_v), .in_a(r6), .in_b(r6), .in_keep(r6), .in_side(m3_s),
      .out_valid(m4_v), .out_prod(r12), .out_keep(r12k), .out_side(m4_s)
   );

   always_comb begin
      t_clip = r12[WIDE_W-1];
      two12  = t_clip ? WIDE_MAX : {r12[WIDE_W-2:0], 1'b0};
      neg_in = two12 < r12k;
      mag_in = neg_in ? (r12k - two12) : (two12 - r12k);
      sc_in     = m4_s;
      sc_in.neg = neg_in;
      sc_in.sat = m4_s.sat | t_clip;
   end

   clj_mulq u_mul_eps (
      .clock, .reset, .en,
      .in_valid(vc_ff), .in_a(mag_ff), .in_b({17'd0, well_depth_ff, 16'd0}),
      .in_keep(mag_ff), .in_side(sc_ff),
      .out_valid(m5_v), .out_prod(g), .out_keep(gk), .out_side(m5_s)
   );

   always_comb begin
      g_clip    = g > SCALE_LIM;
      g24_in    = g_clip ? WIDE_MAX : ({g[WIDE_W-5:0], 4'd0} + {g[WIDE_W-4:0], 3'd0});
      sg_in     = m5_s;
      sg_in.sat = m5_s.sat | g_clip | (gk != gk);
   end

   clj_div u_div_force (
      .clock, .reset, .en,
      .in_valid (vg_ff),
      .in_num   (g24_ff),
      .in_side  (sg_ff),
      .out_valid(d2_v),
      .out_quo  (fm),
      .out_side (d2_s)
   );

   clj_apply u_apply (
      .clock, .reset, .en,
      .in_valid  (d2_v),
      .in_mag    (fm),
      .in_side   (d2_s),
      .out_valid (ap_v),
      .out_force (frc),
      .out_within(in_cut),
      .out_sat   (sat)
   );

   assign rsp_ch.valid         = ap_v;
   assign rsp_ch.force_out_x   = frc[0];
   assign rsp_ch.force_out_y   = frc[1];
   assign rsp_ch.force_out_z   = frc[2];
   assign rsp_ch.within_cutoff = in_cut;
   assign rsp_ch.saturated     = sat;

endmodule

// ===== test/cutoff_lj_contact_force_test.sv =====
// Self-checking testbench for the cut-off Lennard-Jones contact force pipeline.
module cutoff_lj_contact_force_test;
   import clj_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int  DRAIN_CYCLES = 160;
   localparam int  QUIET_LIMIT  = 3000;
   localparam longint FORCE_HI  = 64'sh7FFF_FFFF_FFFF;
   localparam longint FORCE_LO  = -64'sh8000_0000_0000;
   localparam int  KIND_WELL    = 0;
   localparam int  KIND_RAW     = 1;
   localparam int  KIND_FAR     = 2;

   typedef struct {
      logic [30:0]        ra;
      logic [30:0]        rb;
      logic signed [31:0] gap;
      logic signed [15:0] n [AXES];
      logic signed [47:0] fin [AXES];
   } contact_type;

   typedef struct {
      logic [47:0] fout [AXES];
      logic        near;
      logic        sat;
   } force_type;

   logic clock;
   logic reset;

   clj_req_if req_ch ();
   clj_rsp_if rsp_ch ();
   clj_csr_if csr_ch ();

   cutoff_lj_contact_force DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [30:0] eps_q;
   logic [30:0] sigma_q;
   logic [30:0] cut_q;

   contact_type pending_contacts [$];
   force_type   expected_forces [$];
   int  errors;
   int  quiet_cycles;
   int  send_gap;
   int  recv_gap;
   int  hold_cycles;
   bit  calm;
   bit  req_taken;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b, inout logic sat);
      logic [127:0] p;
      p = a * b;
      if (p[127:96] != 0) begin
         sat = 1'b1;
         return WIDE_MAX;
      end
      return p[95:32];
   endfunction

   function automatic force_type contact_force(contact_type c);
      force_type r;
      longint d, f, p, q, v;
      logic [63:0] ud, rho, r2, r4, r6, r12, two12, mag, g, fm;
      logic neg;
      logic sat;
      sat = 1'b0;
      f = 0;
      d = longint'(c.gap) + longint'(c.ra) + longint'(c.rb);
      r.near = d < longint'(cut_q);
      if (r.near) begin
         if (d <= 0) begin
            f = FORCE_HI;
            sat = 1'b1;
         end else begin
            ud = d;
            rho = ({33'd0, sigma_q} << 32) / ud;
            r2 = mulq(rho, rho, sat);
            r4 = mulq(r2, r2, sat);
            r6 = mulq(r4, r2, sat);
            r12 = mulq(r6, r6, sat);
            if (r12[63]) begin
               sat = 1'b1;
               two12 = WIDE_MAX;
            end else begin
               two12 = r12 << 1;
            end
            neg = two12 < r6;
            mag = neg ? r6 - two12 : two12 - r6;
            g = mulq(mag, {17'd0, eps_q, 16'd0}, sat);
            if (g > SCALE_LIM) begin
               sat = 1'b1;
               g = WIDE_MAX;
            end else begin
               g = g * LJ_SCALE;
            end
            fm = g / ud;
            if (fm > FORCE_HI) begin
               sat = 1'b1;
               fm = FORCE_HI;
            end
            f = neg ? -longint'(fm) : longint'(fm);
         end
      end
      for (int k = 0; k < AXES; k++) begin
         p = f * longint'(c.n[k]);
         q = p >>> 14;
         v = longint'(c.fin[k]) - q;
         if (v > FORCE_HI) begin
            v = FORCE_HI;
            sat = 1'b1;
         end else if (v < FORCE_LO) begin
            v = FORCE_LO;
            sat = 1'b1;
         end
         r.fout[k] = v[47:0];
      end
      r.sat = sat;
      return r;
   endfunction

   // Kinds: well-formed near the potential well, any bit pattern, and overlapping or
   // beyond the cutoff.
   function automatic contact_type random_contact(int kind);
      contact_type c;
      longint d, lo, hi;
      for (int k = 0; k < AXES; k++) begin
         c.n[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                  : 16'($signed($urandom_range(0, 32768)) - 16384);
         c.fin[k] = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom})
                    : 48'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      end
      if (kind == KIND_RAW) begin
         c.ra = 31'($urandom);
         c.rb = 31'($urandom);
         c.gap = $urandom;
         return c;
      end
      lo = sigma_q / 2 + 1;
      hi = cut_q;
      if (kind == KIND_FAR) begin
         d = ($urandom_range(0, 1) == 0) ? -longint'($urandom_range(0, 1 << 20))
             : hi + $urandom_range(0, 1 << 16);
      end else if (hi <= lo) begin
         d = $urandom_range(1, 32'(hi > 1 ? hi : 1));
      end else begin
         d = $urandom_range(32'(lo), 32'(hi - 1));
      end
      c.ra = 31'($urandom_range(0, 1 << 30));
      c.rb = 31'($urandom_range(0, 1 << 30));
      c.gap = 32'(d - longint'(c.ra) - longint'(c.rb));
      return c;
   endfunction

   function automatic contact_type directed_contact(longint ra, longint rb, longint gap,
                                                     int nval, longint fval);
      contact_type c;
      c.ra = 31'(ra);
      c.rb = 31'(rb);
      c.gap = 32'(gap);
      for (int k = 0; k < AXES; k++) begin
         c.n[k] = 16'((k == 1) ? -nval : nval);
         c.fin[k] = 48'((k == 2) ? -fval - 1 : fval);
      end
      return c;
   endfunction

   task automatic enqueue(contact_type c);
      pending_contacts = {pending_contacts, c};
   endtask

   // Sender: prediction at the accepting edge, new word at the falling edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_forces = {expected_forces, contact_force(pending_contacts.pop_front())};
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         send_gap <= $urandom_range(0, 11);
         req_ch.valid <= 1'b0;
      end else if (pending_contacts.size() > 0) begin
         contact_type c;
         c = pending_contacts[0];
         req_ch.valid <= 1'b1;
         req_ch.radius_a <= c.ra;
         req_ch.radius_b <= c.rb;
         req_ch.surface_gap <= c.gap;
         req_ch.normal_x <= c.n[0];
         req_ch.normal_y <= c.n[1];
         req_ch.normal_z <= c.n[2];
         req_ch.force_in_x <= c.fin[0];
         req_ch.force_in_y <= c.fin[1];
         req_ch.force_in_z <= c.fin[2];
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Receiver: stalls in bursts, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         recv_gap <= $urandom_range(0, 11);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("ERROR: %s got %0h expected %0h", what, got, want);
   endtask

   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_forces.size() == 0) begin
            report("unexpected result word", 0, 0);
         end else begin
            want = expected_forces.pop_front();
            if (rsp_ch.force_out_x !== want.fout[0])
               report("force_out_x", rsp_ch.force_out_x, want.fout[0]);
            if (rsp_ch.force_out_y !== want.fout[1])
               report("force_out_y", rsp_ch.force_out_y, want.fout[1]);
            if (rsp_ch.force_out_z !== want.fout[2])
               report("force_out_z", rsp_ch.force_out_z, want.fout[2]);
            if (rsp_ch.within_cutoff !== want.near)
               report("within_cutoff", rsp_ch.within_cutoff, want.near);
            if (rsp_ch.saturated !== want.sat)
               report("saturated", rsp_ch.saturated, want.sat);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [30:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_WELL_DEPTH: eps_q = value;
         REG_CONTACT_LENGTH: sigma_q = value;
         REG_CUTOFF_DISTANCE: cut_q = value;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain;
      do @(posedge clock);
      while (pending_contacts.size() != 0 || req_ch.valid || expected_forces.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         enqueue(random_contact(kind < 7 ? KIND_WELL : (kind < 9 ? KIND_RAW : KIND_FAR)));
      end
   endtask

   initial begin
      errors = 0;
      quiet_cycles = 0;
      send_gap = 0;
      recv_gap = 0;
      hold_cycles = 0;
      calm = 1'b0;
      req_taken = 1'b0;
      eps_q = WELL_DEPTH_RESET;
      sigma_q = CONTACT_LENGTH_RESET;
      cut_q = CUTOFF_DISTANCE_RESET;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.radius_a = '0;
      req_ch.radius_b = '0;
      req_ch.surface_gap = '0;
      req_ch.normal_x = '0;
      req_ch.normal_y = '0;
      req_ch.normal_z = '0;
      req_ch.force_in_x = '0;
      req_ch.force_in_y = '0;
      req_ch.force_in_z = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_WELL_DEPTH;
      csr_ch.data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed contacts with the register defaults.
      enqueue(directed_contact(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 16384, 0));
      enqueue(directed_contact(0, 0, -64'sh8000_0000, 16384, 0));
      enqueue(directed_contact(0, 0, 0, -16384, 1000));
      enqueue(directed_contact(0, 0, 73561, 16384, 0));
      enqueue(directed_contact(0, 0, 73560, 16384, 0));
      enqueue(directed_contact(32768, 32768, 0, 11585, 5));
      enqueue(directed_contact(0, 0, 1, 16384, 0));
      enqueue(directed_contact(0, 0, 45000, -32768, FORCE_HI));
      enqueue(directed_contact(0, 0, 60000, 32767, FORCE_HI));
      enqueue(directed_contact(0, 0, 70000, 0, FORCE_LO));
      enqueue(directed_contact(31'h7FFF_FFFF, 0, -64'sh7FFF_0000, -16384, -12345));
      enqueue(directed_contact(100, 200, -500, 16384, FORCE_HI));
      random_phase(200);
      drain();

      // Zero epsilon and sigma, widest cutoff.
      write_reg(REG_WELL_DEPTH, 31'd0);
      write_reg(REG_CONTACT_LENGTH, 31'd0);
      write_reg(REG_CUTOFF_DISTANCE, 31'h7FFF_FFFF);
      write_reg(REG_UNUSED, 31'h1234_5678);
      enqueue(directed_contact(0, 0, 65536, 16384, 77));
      enqueue(directed_contact(0, 0, -1, 16384, 77));
      random_phase(200);
      drain();

      // Largest epsilon and sigma: saturation throughout the chain.
      write_reg(REG_WELL_DEPTH, 31'h7FFF_FFFF);
      write_reg(REG_CONTACT_LENGTH, 31'h7FFF_FFFF);
      random_phase(200);
      drain();

      // Zero cutoff, then a mid-range setting with the long receiver hold-off.
      write_reg(REG_CUTOFF_DISTANCE, 31'd0);
      random_phase(100);
      drain();
      write_reg(REG_WELL_DEPTH, 31'($urandom_range(1 << 12, 1 << 20)));
      write_reg(REG_CONTACT_LENGTH, 31'($urandom_range(1 << 14, 1 << 18)));
      write_reg(REG_CUTOFF_DISTANCE, 31'(sigma_q * 2));
      hold_cycles = 600;
      random_phase(400);
      drain();

      // Defaults again; the second half runs with no idling on either side.
      write_reg(REG_WELL_DEPTH, WELL_DEPTH_RESET);
      write_reg(REG_CONTACT_LENGTH, CONTACT_LENGTH_RESET);
      write_reg(REG_CUTOFF_DISTANCE, CUTOFF_DISTANCE_RESET);
      random_phase(250);
      do @(posedge clock); while (pending_contacts.size() > 200);
      calm = 1'b1;
      random_phase(250);
      drain();

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
